@@ rtl/core/mvte_pkg.sv @@
`timescale 1ns / 1ps
package mvte_pkg;

    localparam int TONE_COUNT_DEF = 18;
    localparam int MAX_SYMS       = 3;

    localparam int CHAR_W   = 8;
    localparam int DAC_W    = 12;
    localparam int TONE_W   = 5;
    localparam int SYM_W    = 4;
    localparam int SPACE_W  = 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int WORD_W   = 12;
    localparam int SUM_W    = 6;
    localparam int SUM_DEPTH = 1 << SUM_W;
    localparam int CNT_W    = 2;

    localparam int ROM_DEPTH  = 384;
    localparam int ROM_ADDR_W = 9;

    localparam logic [DAC_W-1:0]   BASE_RESET    = 12'd2103;
    localparam logic [SPACE_W-1:0] SPACING_RESET = 8'd36;
    localparam logic [DAC_W-1:0]   DAC_MAX       = 12'hFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_SPACING = 1'd1;

    // Output tdata layout, lowest bit first.
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic capture;
        logic load_word;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic more;
    } t_dp_stat;

    // Packed varicode table; byte 0 is leftmost.
    localparam logic [0:ROM_DEPTH-1][7:0] VARICODE_ROM = {
        136'hf119aff11bcff11deff12f88c22098822a,
        136'hb8822c0d822de8822f899229a9922bc992,
        136'h2de9922f8aa229aaa22bcaa22dea00700b,
        136'h800eba900a99807f0a800cb8900d88b270,
        136'h0ed70098f3400af4500986500ce5600cb6,
        136'h600e800ad8a0780f907f0c903809e4300c,
        136'he33008c45008a5300a87600ab44008d430,
        136'h0b94600fd3200fe2500bd6500df5600997,
        136'h00eaa009faa00ac9904b00b1000cb01000,
        136'hf01009a05000a2100e90000e0630008120,
        136'h0807000802000dd1100cf1100a9200ca90,
        136'h0edab028fab2289bb22abbb22cdbb22efb,
        136'hc2289cc22abcc22cdcc22efcd2289dd22a,
        136'hbdd22cddd22efde2289ee22abee22cdee2,
        136'h2efeb009abb00bcbb00debb00f8cc009ac,
        136'hc00bccc00decc00f8dd009add00bcdd00d,
        136'hedd00f8ee009aee00bcee00deee00f8ff0,
        136'h09aff00bcff00deff01f888119a8811bc8,
        136'h811de8811f899119a9911bc9911de9911f,
        136'h8aa119aaa11bcaa11deaa11f8bb119abb1,
        136'h1bcbb11debb11f8cc119acc11bccc11dec,
        136'hc11f8dd119add11bcdd11dedd11f8ee119,
        80'haee11bcee11deee11f8f
    };

endpackage

@@ rtl/core/mfsk_varicode_tone_encoder.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals                        Content
// s_axis    in         tvalid tready tdata[7:0]       character
// m_axis    out        tvalid tready tdata[23:0] tlast dac_code, tone_index, symbol; last
// cfg       in         we addr[0] data[11:0]          0: base_code, 1: tone_spacing
//
// A character gives one to three tones: the varicode table read is registered,
// the word is then aligned, then one tone per cycle, while m_axis is not
// stalled, passes through the modulo table, multiplier and saturating adder.
// Reset is synchronous and active low; it clears the stored tone and restores
// the register defaults. A stalled m_axis holds the tone sequencer in place.
module mfsk_varicode_tone_encoder
    import mvte_pkg::*;
#(
    parameter int TONE_COUNT = TONE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [CHAR_W-1:0]      i_s_axis_tdata,  // [7:0] character
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [11:0] dac_code, [16:12] tone_index, [20:17] symbol, [23:21] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mvte_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    mvte_datapath #(
        .TONE_COUNT (TONE_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char          (i_s_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

@@ rtl/core/mvte_ctrl.sv @@
`timescale 1ns / 1ps
module mvte_ctrl
    import mvte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SYMS - 1);

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_fin;

    // The symbol limit ends the character even if the next nibble continues.
    assign w_fin = !i_stat.more || (r_cnt == CNT_LAST);

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.capture   = i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.load_word = 1'b1;
                n_cnt           = '0;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_fin;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (w_fin) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_fetch_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (r_state == ST_EMIT))
        else $error("fetch not followed by emit");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt <= CNT_LAST))
        else $error("symbol count beyond limit");

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == ST_EMIT))
        else $error("emit outside emit state");

endmodule

@@ rtl/core/mvte_datapath.sv @@
`timescale 1ns / 1ps
module mvte_datapath
    import mvte_pkg::*;
#(
    parameter int TONE_COUNT = TONE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CHAR_W-1:0]      i_char,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_m_axis_tready,
    output logic                   o_m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    logic [DAC_W-1:0]      r_base;
    logic [SPACE_W-1:0]    r_spacing;
    logic [TONE_W-1:0]     r_prev_tone;
    logic [7:0]            r_rom_lo;
    logic [7:0]            r_rom_hi;
    logic                  r_odd;
    logic [WORD_W-1:0]     r_word;
    logic                  r_out_valid;
    logic [DAC_W-1:0]      r_out_dac;
    logic [TONE_W-1:0]     r_out_tone;
    logic [SYM_W-1:0]      r_out_sym;
    logic                  r_out_last;

    logic [ROM_ADDR_W-1:0] w_addr;
    logic [ROM_ADDR_W-1:0] w_addr_p1;
    logic [SYM_W-1:0]      w_sym;
    logic [SUM_W-1:0]      w_sum;
    logic [TONE_W-1:0]     w_tone;
    logic [DAC_W:0]        w_product;
    logic [DAC_W+1:0]      w_dac_sum;
    logic [DAC_W-1:0]      w_dac;
    logic [TONE_W-1:0]     w_mod_tab [0:SUM_DEPTH-1];

    // Remainder table over every reachable sum, built at elaboration.
    for (genvar g = 0; g < SUM_DEPTH; g++) begin : g_mod
        assign w_mod_tab[g] = TONE_W'(g % TONE_COUNT);
    end

    // Byte offset is character * 3 / 2.
    assign w_addr    = ROM_ADDR_W'(i_char) + ROM_ADDR_W'(i_char[CHAR_W-1:1]);
    assign w_addr_p1 = w_addr + ROM_ADDR_W'(1);

    assign w_sym     = r_word[SYM_W-1:0];
    assign w_sum     = SUM_W'(r_prev_tone) + SUM_W'(2) + SUM_W'(w_sym);
    assign w_tone    = w_mod_tab[w_sum];
    assign w_product = (DAC_W+1)'(w_tone) * (DAC_W+1)'(r_spacing);
    assign w_dac_sum = (DAC_W+2)'(r_base) + (DAC_W+2)'(w_product);
    assign w_dac     = (w_dac_sum > (DAC_W+2)'(DAC_MAX)) ? DAC_MAX : w_dac_sum[DAC_W-1:0];

    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;
    assign o_stat.more     = r_word[2*SYM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_RESET;
            r_spacing <= SPACING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BASE_CODE:    r_base    <= i_cfg_data[DAC_W-1:0];
                CFG_TONE_SPACING: r_spacing <= i_cfg_data[SPACE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Two-port table read, data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rom_lo <= VARICODE_ROM[w_addr];
            r_rom_hi <= VARICODE_ROM[w_addr_p1];
            r_odd    <= i_char[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word <= r_odd ? {r_rom_hi, r_rom_lo[7:4]} : {r_rom_hi[3:0], r_rom_lo};
        end else if (i_cmd.emit) begin
            r_word <= {{SYM_W{1'b0}}, r_word[WORD_W-1:SYM_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tone <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_prev_tone <= w_tone;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dac  <= w_dac;
            r_out_tone <= w_tone;
            r_out_sym  <= w_sym;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-DAC_W-TONE_W-SYM_W){1'b0}},
                              r_out_sym, r_out_tone, r_out_dac};

    a_prev_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_prev_tone} < (TONE_W+1)'(TONE_COUNT))
        else $error("stored tone out of range");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted tone not presented");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_stat.out_free)
        else $error("output register overwritten");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import mvte_pkg::*;

    localparam int TONES       = TONE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TABLE_BYTES = 385;

    // Primary-alphabet varicode table, byte 0 leftmost.
    localparam logic [0:TABLE_BYTES-1][7:0] CODE_TABLE = {
        136'hf119aff11bcff11deff12f88c22098822a,
        136'hb8822c0d822de8822f899229a9922bc992,
        136'h2de9922f8aa229aaa22bcaa22dea00700b,
        136'h800eba900a99807f0a800cb8900d88b270,
        136'h0ed70098f3400af4500986500ce5600cb6,
        136'h600e800ad8a0780f907f0c903809e4300c,
        136'he33008c45008a5300a87600ab44008d430,
        136'h0b94600fd3200fe2500bd6500df5600997,
        136'h00eaa009faa00ac9904b00b1000cb01000,
        136'hf01009a05000a2100e90000e0630008120,
        136'h0807000802000dd1100cf1100a9200ca90,
        136'h0edab028fab2289bb22abbb22cdbb22efb,
        136'hc2289cc22abcc22cdcc22efcd2289dd22a,
        136'hbdd22cddd22efde2289ee22abee22cdee2,
        136'h2efeb009abb00bcbb00debb00f8cc009ac,
        136'hc00bccc00decc00f8dd009add00bcdd00d,
        136'hedd00f8ee009aee00bcee00deee00f8ff0,
        136'h09aff00bcff00deff01f888119a8811bc8,
        136'h811de8811f899119a9911bc9911de9911f,
        136'h8aa119aaa11bcaa11deaa11f8bb119abb1,
        136'h1bcbb11debb11f8cc119acc11bccc11dec,
        136'hc11f8dd119add11bcdd11dedd11f8ee119,
        88'haee11bcee11deee11f8ff6
    };

    typedef struct packed {
        logic [DAC_W-1:0]  dac;
        logic [TONE_W-1:0] tone;
        logic [SYM_W-1:0]  sym;
        logic              last;
    } t_tone;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [CHAR_W-1:0]      s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_last;

    // Predictor state and register copies.
    logic [TONE_W-1:0]  tone_state = '0;
    logic [DAC_W-1:0]   cfg_base = BASE_RESET;
    logic [SPACE_W-1:0] cfg_spacing = SPACING_RESET;

    t_tone tone_queue[$];
    t_tone want;
    logic  tx_idle = 1'b1;
    logic  rx_idle = 1'b1;
    int    rx_hold_cycles = 0;
    int    cycle_count = 0;
    int    mismatches = 0;
    int    chars_sent = 0;
    int    tones_seen = 0;
    int    settings_used = 1;

    mfsk_varicode_tone_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] character
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [11:0] dac_code, [16:12] tone_index, [20:17] symbol, [23:21] zero
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d with %0d tones outstanding",
                     cycle_count, tone_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Word for one character; odd characters start one nibble higher.
    function automatic logic [15:0] code_word(input logic [CHAR_W-1:0] ch);
        int addr;
        logic [15:0] w;
        addr = (int'(ch) * 3) / 2;
        w = {CODE_TABLE[addr + 1], CODE_TABLE[addr]};
        if (ch[0])
            w = w >> 4;
        return w;
    endfunction

    task automatic encode_char(input logic [CHAR_W-1:0] ch);
        logic [15:0] w;
        int    sum;
        int    dac;
        t_tone t;
        w = code_word(ch);
        for (int k = 0; k < MAX_SYMS; k++) begin
            t.sym  = w[4*k +: 4];
            sum    = int'(tone_state) + 2 + int'(t.sym);
            t.tone = TONE_W'(sum % TONES);
            dac    = int'(cfg_base) + int'(t.tone) * int'(cfg_spacing);
            t.dac  = (dac > int'(DAC_MAX)) ? DAC_MAX : DAC_W'(dac);
            tone_state = t.tone;
            t.last = !w[4*(k+1) + 3] || (k == MAX_SYMS - 1);
            tone_queue.push_back(t);
            if (t.last)
                break;
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= ch;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        encode_char(ch);
        chars_sent++;
    endtask

    // Stop offering and wait until every predicted tone has been checked.
    task automatic drain();
        s_valid <= 1'b0;
        while (tone_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_BASE_CODE)
            cfg_base = val[DAC_W-1:0];
        else
            cfg_spacing = val[SPACE_W-1:0];
    endtask

    task automatic set_tones(input logic [DAC_W-1:0] base, input logic [SPACE_W-1:0] step);
        cfg_write(CFG_BASE_CODE, base);
        // Upper bits of the spacing write are ignored by the block.
        cfg_write(CFG_TONE_SPACING, {4'($urandom), step});
        settings_used++;
    endtask

    // Receiver: per-result random wait, plus an optional long hold-off.
    initial begin
        int gap;
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid)
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            tones_seen++;
            if (tone_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected tone transfer: tdata=%h tlast=%b", m_data, m_last);
            end else begin
                want = tone_queue.pop_front();
                if (m_data[11:0] !== want.dac || m_data[16:12] !== want.tone ||
                    m_data[20:17] !== want.sym || m_data[23:21] !== 3'b000 ||
                    m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Tone mismatch at cycle %0d: expected dac=%0d tone=%0d ",
                                  "sym=%h last=%b, got dac=%0d tone=%0d sym=%h pad=%b last=%b"},
                                 cycle_count, want.dac, want.tone, want.sym, want.last,
                                 m_data[11:0], m_data[16:12], m_data[20:17], m_data[23:21],
                                 m_last);
                end
            end
        end
    end

    // Extremes of the character, every word length, the three-symbol cutoff
    // and DAC saturation, starting from the reset register values.
    task automatic test_directed();
        int pick[4] = '{-1, -1, -1, -1};
        int n;
        logic [15:0] w;
        for (int c = 0; c < 256; c++) begin
            w = code_word(c[7:0]);
            n = 1;
            while (n < MAX_SYMS && w[4*n + 3])
                n++;
            if (n == MAX_SYMS && w[15])
                n = 0;
            if (pick[n] < 0)
                pick[n] = c;
        end
        foreach (pick[i])
            if (pick[i] >= 0)
                send_char(pick[i][7:0]);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'hFE);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'h55);
        send_char(8'hAA);
        drain();
        set_tones(12'hFFF, 8'hFF);
        send_char(8'h00);
        send_char(8'hFF);
        if (pick[0] >= 0)
            send_char(pick[0][7:0]);
        drain();
        set_tones(12'd4000, 8'd10);
        repeat (4) send_char(8'($urandom));
        drain();
        set_tones(12'h000, 8'h00);
        send_char(8'hFF);
        send_char(8'h00);
        drain();
    endtask

    task automatic test_config_sweep();
        logic [DAC_W-1:0]   bases[7]  = '{BASE_RESET, 12'h000, 12'hFFF, 12'h000, 12'hFFF,
                                          12'h800, 12'h7FF};
        logic [SPACE_W-1:0] steps[7]  = '{SPACING_RESET, 8'h00, 8'hFF, 8'hFF, 8'h00,
                                          8'h80, 8'h7F};
        for (int p = 0; p < 7; p++) begin
            if (p >= 5)
                set_tones(12'($urandom), 8'($urandom));
            else
                set_tones(bases[p], steps[p]);
            repeat (13) send_char(8'($urandom));
            drain();
        end
        set_tones(BASE_RESET, SPACING_RESET);
    endtask

    // The receiver stalls for a long stretch while characters keep coming,
    // so the block fills up and holds off its input.
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold_cycles = 300;
        repeat (24) send_char(8'($urandom));
        drain();
        tx_idle = 1'b1;
    endtask

    task automatic test_random();
        for (int chunk = 0; chunk < 14; chunk++) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (20) send_char(8'($urandom));
            if (chunk % 5 == 4) begin
                drain();
                set_tones(12'($urandom), 8'($urandom));
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        $display("Sent %0d characters, checked %0d tones across %0d DAC settings.",
                 chars_sent, tones_seen, settings_used);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
